### rtl/video_glitch_pixel_effect_top_defines.svh
// assertion macros used by the top-level rtl file
`ifndef VIDEO_GLITCH_PIXEL_EFFECT_TOP_DEFINES_SVH
`define VIDEO_GLITCH_PIXEL_EFFECT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define VGPE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define VGPE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VGPE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define VGPE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### rtl/vgpe_pkg.sv
`default_nettype none

package vgpe_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    // lane operations
    localparam logic [1:0] OP_HOLD  = 2'd0;
    localparam logic [1:0] OP_SCALE = 2'd1;
    localparam logic [1:0] OP_DIV   = 2'd2;
    localparam logic [1:0] OP_MIX   = 2'd3;

    // x / 100 == (x * 5243) >> 19 for every x below 43690
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [6:0] PCT_FULL   = 7'd100;
    localparam logic [7:0] CHAN_MAX   = 8'd255;
    localparam logic [5:0] BAND_BASE  = 6'd12;
    localparam logic [1:0] FRAME_SUB  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_EFFECT_ON  = 3'd0;
    localparam logic [2:0] CFG_PACKED_RGB = 3'd1;
    localparam logic [2:0] CFG_SCAN_STR   = 3'd2;
    localparam logic [2:0] CFG_BAND_STR   = 3'd3;
    localparam logic [2:0] CFG_RGB_SPLIT  = 3'd4;

endpackage

`default_nettype wire

### rtl/vgpe_lane.sv
`default_nettype none

module vgpe_lane (
    input  wire logic       i_clk,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_pix,
    input  wire logic [7:0] i_other,
    input  wire logic [6:0] i_scale,
    input  wire logic [6:0] i_weight,
    output logic      [7:0] o_val
);

    logic [14:0]        r_acc;
    logic [14:0]        n_acc;
    logic [7:0]         r_val;
    logic [7:0]         n_val;
    logic [27:0]        div_prod;
    logic signed [8:0]  diff;
    logic signed [16:0] mix_prod;
    logic signed [16:0] mix_sum;
    logic [14:0]        base;

    always_comb begin
        div_prod = {13'd0, r_acc} * {15'd0, vgpe_pkg::RECIP_100};
        // v*100 + (o - v)*t is the same as o*t + v*(100 - t)
        diff     = $signed({1'b0, i_other}) - $signed({1'b0, r_val});
        mix_prod = $signed({{8{diff[8]}}, diff}) * $signed({10'd0, i_weight});
        base     = {7'd0, r_val} * {8'd0, vgpe_pkg::PCT_FULL};
        mix_sum  = $signed({2'b00, base}) + mix_prod;
        n_acc    = r_acc;
        n_val    = r_val;
        case (i_op)
            vgpe_pkg::OP_SCALE: begin
                n_acc = {7'd0, i_pix} * {8'd0, i_scale};
            end
            vgpe_pkg::OP_DIV: begin
                n_val = div_prod[vgpe_pkg::RECIP_SHIFT +: 8];
            end
            vgpe_pkg::OP_MIX: begin
                n_acc = mix_sum[14:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

### rtl/vgpe_ring.sv
`default_nettype none

module vgpe_ring #(
    parameter int AW = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire vgpe_pkg::t_pix  i_wdata,
    input  wire logic            i_re,
    input  wire logic [AW-1:0]   i_raddr_red,
    input  wire logic [AW-1:0]   i_raddr_mid,
    input  wire logic [AW-1:0]   i_raddr_blue,
    output vgpe_pkg::t_pix       o_rdata
);

    localparam int RD = 1 << AW;

    logic [7:0]     r_mem_red [0:RD-1];
    logic [15:0]    r_mem_gb  [0:RD-1];
    vgpe_pkg::t_pix r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_red[i_waddr] <= i_wdata.red;
            r_mem_gb[i_waddr]  <= {i_wdata.green, i_wdata.blue};
        end
        if (i_re) begin
            r_rdata.red   <= r_mem_red[i_raddr_red];
            r_rdata.green <= r_mem_gb[i_raddr_mid][15:8];
            r_rdata.blue  <= r_mem_gb[i_raddr_blue][7:0];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/video_glitch_pixel_effect_top.sv
// Raster glitch effect on a pixel stream, packed RGB or a single luma byte.
// Input channel: i_in_valid / o_in_ready with the pixel bytes and the line
// and frame end marks. Output channel: o_out_valid / i_out_ready with the
// processed pixel and its end marks. Configuration: i_cfg_valid /
// o_cfg_ready with a register index and data; always ready. It must be
// written only while the block is idle, which the block does not enforce.
// Pixels are processed one at a time. After a transfer the pixel passes
// through the per-channel multiply and divide-by-100 lanes (scale, divide,
// blend, divide), then the ring write and the emit check; each result then
// takes a ring read in the check state and an output load in the emit
// state. The red/blue split delays output by the split setting in pixels
// (saturated to MAX_SPLIT, zero in luma mode or with the effect off) and
// a line end flushes the pixels still held.
// The output register holds a result while the receiver stalls; the
// sequencer waits on it and takes no new pixel until all results of the
// current one are loaded.
// Reset restores the register defaults and clears the line, frame and
// column counters; the pixel ring needs no clearing.
`default_nettype none

`include "video_glitch_pixel_effect_top_defines.svh"

module video_glitch_pixel_effect_top #(
    parameter int MAX_SPLIT       = 20,
    parameter int MAX_LINE_PIXELS = 4096,
    parameter int BAND_LINES      = 180
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [6:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_red_or_luma,
    input  wire logic [7:0] i_green_in,
    input  wire logic [7:0] i_blue_in,
    input  wire logic       i_line_last,
    input  wire logic       i_frame_last,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_red_or_luma,
    output logic [7:0]      o_out_green,
    output logic [7:0]      o_out_blue,
    output logic            o_out_line_last,
    output logic            o_out_frame_last
);

    localparam int AW = $clog2(2 * MAX_SPLIT + 2);
    localparam int PW = $clog2(MAX_SPLIT + 2);
    localparam int CW = $clog2(MAX_LINE_PIXELS + 1);
    localparam int BW = $clog2(BAND_LINES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_DIV1  = 3'd2;
    localparam logic [2:0] ST_MIX   = 3'd3;
    localparam logic [2:0] ST_DIV2  = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;
    localparam logic [2:0] ST_CHECK = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    // configuration
    logic       r_effect_on;
    logic       r_packed_rgb;
    logic [6:0] r_scan_str;
    logic [6:0] r_band_str;
    logic [4:0] r_rgb_split;

    // control state
    logic [2:0]    r_state, n_state;
    logic [PW-1:0] r_pending, n_pending;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_wp, n_wp;
    logic [1:0]    r_lmod4, n_lmod4;
    logic [BW-1:0] r_lband, n_lband;
    logic [1:0]    r_fsub, n_fsub;
    logic [1:0]    r_fthird, n_fthird;
    logic [BW-1:0] r_bstart, n_bstart;
    logic          r_out_valid, n_out_valid;

    // payload
    vgpe_pkg::t_pix r_in;
    logic           r_ll;
    logic           r_fl;
    logic           r_scan;
    logic           r_band;
    vgpe_pkg::t_pix r_out;
    logic           r_out_ll;
    logic           r_out_fl;

    logic          in_xfer;
    logic          out_free;
    logic          load_out;
    logic          emit;
    logic          line_end;
    logic [6:0]    ss_sat;
    logic [6:0]    bs_sat;
    logic [4:0]    sp;
    logic [6:0]    scale_k;
    logic [6:0]    w_red;
    logic [6:0]    w_gb;
    logic [5:0]    band_height;
    logic          scan_hit;
    logic          band_hit;
    logic [1:0]    scan_sum;
    logic [BW:0]   bstart_inc;
    logic [CW-1:0] p_ext;
    logic [CW-1:0] sp_ext;
    logic [CW-1:0] eidx;
    logic [AW-1:0] eslot;
    logic [AW-1:0] sp_addr;
    logic [AW-1:0] addr_red;
    logic [AW-1:0] addr_blue;
    logic [1:0]    lane_op;
    logic [7:0]    val_r, val_g, val_b;
    logic [7:0]    oth_r, oth_g, oth_b;
    vgpe_pkg::t_pix wr_pix;
    vgpe_pkg::t_pix rd_pix;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign line_end    = r_ll || r_fl;

    // saturated settings, lane scale and weights, scan and band hits
    always_comb begin
        ss_sat = (r_scan_str > vgpe_pkg::PCT_FULL) ? vgpe_pkg::PCT_FULL : r_scan_str;
        bs_sat = (r_band_str > vgpe_pkg::PCT_FULL) ? vgpe_pkg::PCT_FULL : r_band_str;
        if (!r_effect_on || !r_packed_rgb) begin
            sp = 5'd0;
        end else if (r_rgb_split > 5'(MAX_SPLIT)) begin
            sp = 5'(MAX_SPLIT);
        end else begin
            sp = r_rgb_split;
        end
        scale_k   = r_scan ? (vgpe_pkg::PCT_FULL - {1'b0, ss_sat[6:1]}) : vgpe_pkg::PCT_FULL;
        w_red     = r_band ? bs_sat : 7'd0;
        w_gb      = (r_band && r_packed_rgb) ? bs_sat : 7'd0;
        band_height = vgpe_pkg::BAND_BASE + {1'b0, bs_sat[6:2]};
        scan_sum  = r_lmod4 + r_fthird;
        scan_hit  = r_effect_on && (scan_sum == 2'd0);
        band_hit  = r_effect_on && (r_lband >= r_bstart)
                    && (10'(r_lband) < (10'(r_bstart) + 10'(band_height)));
    end

    // channel lanes: scale, divide, blend, divide
    always_comb begin
        case (r_state)
            ST_SCALE: lane_op = vgpe_pkg::OP_SCALE;
            ST_DIV1:  lane_op = vgpe_pkg::OP_DIV;
            ST_MIX:   lane_op = vgpe_pkg::OP_MIX;
            ST_DIV2:  lane_op = vgpe_pkg::OP_DIV;
            default:  lane_op = vgpe_pkg::OP_HOLD;
        endcase
        if (r_packed_rgb) begin
            oth_r = val_b;
            oth_g = val_r;
            oth_b = val_g;
        end else begin
            oth_r = vgpe_pkg::CHAN_MAX - val_r;
            oth_g = val_g;
            oth_b = val_b;
        end
    end

    vgpe_lane u_lane_r (
        .i_clk    (i_clk),
        .i_op     (lane_op),
        .i_pix    (r_in.red),
        .i_other  (oth_r),
        .i_scale  (scale_k),
        .i_weight (w_red),
        .o_val    (val_r)
    );

    vgpe_lane u_lane_g (
        .i_clk    (i_clk),
        .i_op     (lane_op),
        .i_pix    (r_in.green),
        .i_other  (oth_g),
        .i_scale  (scale_k),
        .i_weight (w_gb),
        .o_val    (val_g)
    );

    vgpe_lane u_lane_b (
        .i_clk    (i_clk),
        .i_op     (lane_op),
        .i_pix    (r_in.blue),
        .i_other  (oth_b),
        .i_scale  (scale_k),
        .i_weight (w_gb),
        .o_val    (val_b)
    );

    assign wr_pix = '{red: val_r, green: val_g, blue: val_b};

    // ring addresses of the oldest held pixel and its split neighbors
    always_comb begin
        p_ext     = CW'(r_pending);
        sp_ext    = CW'(sp);
        eidx      = (r_col >= p_ext) ? (r_col - p_ext) : '0;
        eslot     = r_wp - AW'(r_pending);
        sp_addr   = AW'(sp);
        addr_red  = (eidx >= sp_ext) ? (eslot - sp_addr) : eslot;
        addr_blue = ((p_ext - CW'(1)) >= sp_ext) ? (eslot + sp_addr) : eslot;
        emit      = (r_pending != '0) && (line_end || (p_ext > sp_ext));
    end

    vgpe_ring #(
        .AW (AW)
    ) u_ring (
        .i_clk        (i_clk),
        .i_we         (r_state == ST_WRITE),
        .i_waddr      (r_wp),
        .i_wdata      (wr_pix),
        .i_re         ((r_state == ST_CHECK) && emit),
        .i_raddr_red  (addr_red),
        .i_raddr_mid  (eslot),
        .i_raddr_blue (addr_blue),
        .o_rdata      (rd_pix)
    );

    assign load_out = (r_state == ST_EMIT) && out_free;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_col     = r_col;
        n_wp      = r_wp;
        n_lmod4   = r_lmod4;
        n_lband   = r_lband;
        n_fsub    = r_fsub;
        n_fthird  = r_fthird;
        n_bstart  = r_bstart;
        bstart_inc = {1'b0, r_bstart} + (BW + 1)'(3);
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: n_state = ST_DIV1;
            ST_DIV1:  n_state = ST_MIX;
            ST_MIX:   n_state = ST_DIV2;
            ST_DIV2:  n_state = ST_WRITE;
            ST_WRITE: begin
                n_wp      = r_wp + AW'(1);
                n_pending = r_pending + PW'(1);
                if (r_col < CW'(MAX_LINE_PIXELS)) begin
                    n_col = r_col + CW'(1);
                end
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (emit) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                    if (line_end) begin
                        n_col     = '0;
                        n_pending = '0;
                        if (r_fl) begin
                            n_lmod4 = 2'd0;
                            n_lband = '0;
                        end else begin
                            n_lmod4 = r_lmod4 + 2'd1;
                            n_lband = (r_lband == BW'(BAND_LINES - 1)) ? '0
                                                                        : r_lband + BW'(1);
                        end
                        if (r_fl && r_effect_on) begin
                            if (r_fsub == vgpe_pkg::FRAME_SUB) begin
                                n_fsub   = 2'd0;
                                n_fthird = r_fthird + 2'd1;
                            end else begin
                                n_fsub = r_fsub + 2'd1;
                            end
                            n_bstart = (bstart_inc >= (BW + 1)'(BAND_LINES))
                                       ? BW'(bstart_inc - (BW + 1)'(BAND_LINES))
                                       : BW'(bstart_inc);
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_pending = r_pending - PW'(1);
                    n_state   = ST_CHECK;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_on  <= 1'b1;
            r_packed_rgb <= 1'b1;
            r_scan_str   <= 7'd40;
            r_band_str   <= 7'd45;
            r_rgb_split  <= 5'd4;
            r_state      <= ST_IDLE;
            r_pending    <= '0;
            r_col        <= '0;
            r_wp         <= '0;
            r_lmod4      <= 2'd0;
            r_lband      <= '0;
            r_fsub       <= 2'd0;
            r_fthird     <= 2'd0;
            r_bstart     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    vgpe_pkg::CFG_EFFECT_ON:  r_effect_on  <= i_cfg_data[0];
                    vgpe_pkg::CFG_PACKED_RGB: r_packed_rgb <= i_cfg_data[0];
                    vgpe_pkg::CFG_SCAN_STR:   r_scan_str   <= i_cfg_data;
                    vgpe_pkg::CFG_BAND_STR:   r_band_str   <= i_cfg_data;
                    vgpe_pkg::CFG_RGB_SPLIT:  r_rgb_split  <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_col       <= n_col;
            r_wp        <= n_wp;
            r_lmod4     <= n_lmod4;
            r_lband     <= n_lband;
            r_fsub      <= n_fsub;
            r_fthird    <= n_fthird;
            r_bstart    <= n_bstart;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.red   <= i_red_or_luma;
            // planar pixels carry no chroma
            r_in.green <= r_packed_rgb ? i_green_in : 8'd0;
            r_in.blue  <= r_packed_rgb ? i_blue_in : 8'd0;
            r_ll       <= i_line_last;
            r_fl       <= i_frame_last;
            r_scan     <= scan_hit;
            r_band     <= band_hit;
        end
        if (load_out) begin
            r_out    <= rd_pix;
            r_out_ll <= line_end && (r_pending == PW'(1));
            r_out_fl <= r_fl && (r_pending == PW'(1));
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_red_or_luma = r_out.red;
    assign o_out_green       = r_out.green;
    assign o_out_blue        = r_out.blue;
    assign o_out_line_last   = r_out_ll;
    assign o_out_frame_last  = r_out_fl;

    `VGPE_ASSERT_IMP(a_pending_bound, i_clk, i_rst_n, 1'b1, r_pending <= PW'(MAX_SPLIT + 1), "held pixel count above ring window")
    `VGPE_ASSERT_NXT(a_emit_loads, i_clk, i_rst_n, (r_state == ST_EMIT) && out_free, o_out_valid, "emitted pixel not presented")
    `VGPE_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, in_xfer, r_state == ST_SCALE, "accepted pixel did not start processing")
    `VGPE_ASSERT_NXT(a_line_flushed, i_clk, i_rst_n, (r_state == ST_CHECK) && !emit && line_end, (r_col == '0) && (r_pending == '0), "line end left pixels held")

endmodule

`default_nettype wire
